/* design/sue_pkg.sv */
package sue_pkg;

  // error codes carried on every result word of a run
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX    = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
  localparam logic [1:0] ERR_BAD_CP     = 2'd3;

  localparam logic [31:0] MAX_CP = 32'h0010_ffff;

  // characters the front looks for
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // run queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // how the back expands a run into output words
  typedef enum logic [1:0] {
    RUN_BYTE,      // one byte, value[7:0]
    RUN_BSL_PAIR,  // backslash, then value[7:0]
    RUN_CP         // code point in value, emitted as utf-8
  } run_kind_e;

  typedef struct packed {
    run_kind_e   kind;
    logic [31:0] value;
    logic        fin;
    logic [1:0]  err;
  } run_t;

  // {digit ok, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* design/sue_front.sv */
module sue_front import sue_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output run_t       run_o
);

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_BSL,
    MODE_X,
    MODE_U4,
    MODE_U8
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] code_q, code_d;
  logic        halt_q, halt_d;
  logic [1:0]  perr_q, perr_d;

  logic        accept;
  logic        emit;
  run_t        run;
  logic [4:0]  hex;
  logic [3:0]  left_dec;
  logic [31:0] code_n;
  logic        halt_n;
  logic [1:0]  perr_n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;
  assign run_o      = run;
  assign hex        = hex_digit(in_byte_i);
  assign left_dec   = (left_q != 4'd0) ? left_q - 4'd1 : left_q;

  // digit accumulation
  always_comb begin
    code_n = code_q;
    halt_n = halt_q;
    perr_n = perr_q;
    if (!halt_q) begin
      if (in_byte_i == CH_QUOTE || in_byte_i == CH_NUL) begin
        halt_n = 1'b1;
        if (perr_q == ERR_NONE) perr_n = ERR_INCOMPLETE;
      end else if (!hex[4]) begin
        halt_n = 1'b1;
        if (perr_q == ERR_NONE) perr_n = ERR_BAD_HEX;
      end else begin
        code_n = {code_q[27:0], hex[3:0]};
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    left_d    = left_q;
    code_d    = code_q;
    halt_d    = halt_q;
    perr_d    = perr_q;
    emit      = 1'b0;
    run.kind  = RUN_BYTE;
    run.value = 32'(in_byte_i);
    run.fin   = final_byte_i;
    run.err   = ERR_NONE;
    case (mode_q)
      MODE_TEXT: begin
        if (in_byte_i == CH_BSL) begin
          if (final_byte_i) begin
            emit    = 1'b1;
            run.err = ERR_INCOMPLETE;
          end else begin
            mode_d = MODE_BSL;
          end
        end else begin
          emit = 1'b1;
        end
      end
      MODE_BSL: begin
        mode_d = MODE_TEXT;
        emit   = 1'b1;
        case (in_byte_i)
          8'h61: run.value = 32'h07; // a
          8'h62: run.value = 32'h08; // b
          8'h66: run.value = 32'h0c; // f
          8'h6e: run.value = 32'h0a; // n
          8'h72: run.value = 32'h0d; // r
          8'h74: run.value = 32'h09; // t
          8'h76: run.value = 32'h0b; // v
          CH_QUOTE, CH_BSL: run.value = 32'(in_byte_i);
          8'h78, 8'h75, 8'h55: begin // x u U
            if (final_byte_i) begin
              // escape opened on the last byte: empty value
              run.value = 32'd0;
              run.err   = ERR_INCOMPLETE;
            end else begin
              emit   = 1'b0;
              code_d = 32'd0;
              halt_d = 1'b0;
              perr_d = ERR_NONE;
              if (in_byte_i == 8'h78) begin
                mode_d = MODE_X;
                left_d = 4'd2;
              end else if (in_byte_i == 8'h75) begin
                mode_d = MODE_U4;
                left_d = 4'd4;
              end else begin
                mode_d = MODE_U8;
                left_d = 4'd8;
              end
            end
          end
          default: run.kind = RUN_BSL_PAIR;
        endcase
      end
      MODE_X, MODE_U4, MODE_U8: begin
        left_d = left_dec;
        code_d = code_n;
        halt_d = halt_n;
        perr_d = perr_n;
        if (left_dec == 4'd0 || final_byte_i) begin
          emit      = 1'b1;
          run.kind  = (mode_q == MODE_X) ? RUN_BYTE : RUN_CP;
          run.value = code_n;
          run.err   = (left_dec != 4'd0 && perr_n == ERR_NONE) ? ERR_INCOMPLETE : perr_n;
          mode_d    = MODE_TEXT;
          left_d    = 4'd0;
          code_d    = 32'd0;
          halt_d    = 1'b0;
          perr_d    = ERR_NONE;
        end
      end
      default: mode_d = MODE_TEXT;
    endcase
    if (final_byte_i) begin
      mode_d = MODE_TEXT;
      left_d = 4'd0;
      code_d = 32'd0;
      halt_d = 1'b0;
      perr_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      left_q <= 4'd0;
      code_q <= 32'd0;
      halt_q <= 1'b0;
      perr_q <= ERR_NONE;
    end else if (accept) begin
      mode_q <= mode_d;
      left_q <= left_d;
      code_q <= code_d;
      halt_q <= halt_d;
      perr_q <= perr_d;
    end
  end

endmodule

/* design/sue_queue.sv */
module sue_queue import sue_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_run_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_valid_o,
  output run_t head_run_o
);

  run_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_run_o   = mem_q[rd_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/sue_back.sv */
module sue_back import sue_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  run_t       head_run_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_run_o,
  output logic       string_done_o,
  output logic [1:0] error_code_o
);

  logic [1:0]       idx_q;
  logic             ovalid_q;
  logic [7:0]       obyte_q;
  logic             obval_q, olast_q, odone_q;
  logic [1:0]       oerr_q;

  logic [3:0][7:0]  bytes;
  logic [2:0]       n;
  logic             bval;
  logic [1:0]       err;
  logic             last;
  logic             load;
  logic [31:0]      v;

  assign v = head_run_i.value;

  // expand the head run into up to four bytes
  always_comb begin
    bytes = '0;
    n     = 3'd1;
    bval  = 1'b1;
    err   = head_run_i.err;
    case (head_run_i.kind)
      RUN_BYTE: bytes[0] = v[7:0];
      RUN_BSL_PAIR: begin
        n        = 3'd2;
        bytes[0] = CH_BSL;
        bytes[1] = v[7:0];
      end
      RUN_CP: begin
        if (v > MAX_CP) begin
          bval = 1'b0;
          err  = ERR_BAD_CP;
        end else if (v < 32'h80) begin
          bytes[0] = v[7:0];
        end else if (v < 32'h800) begin
          n        = 3'd2;
          bytes[0] = {3'b110, v[10:6]};
          bytes[1] = {2'b10, v[5:0]};
        end else if (v < 32'h10000) begin
          n        = 3'd3;
          bytes[0] = {4'b1110, v[15:12]};
          bytes[1] = {2'b10, v[11:6]};
          bytes[2] = {2'b10, v[5:0]};
        end else begin
          n        = 3'd4;
          bytes[0] = {5'b11110, v[20:18]};
          bytes[1] = {2'b10, v[17:12]};
          bytes[2] = {2'b10, v[11:6]};
          bytes[3] = {2'b10, v[5:0]};
        end
      end
      default: bytes[0] = v[7:0];
    endcase
  end

  assign last  = (idx_q == 2'(n - 3'd1));
  assign load  = head_valid_i && (!ovalid_q || out_ready_i);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q    <= last ? 2'd0 : idx_q + 2'd1;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= bytes[idx_q];
      obval_q <= bval;
      olast_q <= last;
      odone_q <= head_run_i.fin;
      oerr_q  <= err;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte_o    = obyte_q;
  assign byte_valid_o  = obval_q;
  assign last_of_run_o = olast_q;
  assign string_done_o = odone_q;
  assign error_code_o  = oerr_q;

endmodule

/* design/string_escape_to_utf8_decoder_core.sv */
// string literal unescaper with utf-8 output
//
// input channel: one body byte of a literal per word (in_byte_i), with
// final_byte_i marking the last body byte; valid/ready handshake
// output channel: one decoded byte per word, with byte_valid_o low only on
// the error word of an out-of-range code point; last_of_run_o marks the
// last word caused by one input word, string_done_o marks words caused by
// the final byte, error_code_o repeats the run's error on each word
// path: a word that produces output is written into the run queue at the
// edge that accepts it and then loaded into the output register, which
// drives the output ports; escape openers and hex digits produce nothing
// throughput: one input word per cycle while each gives at most one byte
// and the queue is not full; a run of n bytes (backslash pair, 2..4 byte
// utf-8) leaves the output register one byte per cycle while out_ready_i
// is high; a two-entry run queue lets the front keep accepting meanwhile
// reset: escape state returns to plain text, queue and output register
// empty; the decoder also returns to plain text after every final byte
// stall: a receiver holding out_ready_i low freezes the output word, the
// queue fills and then in_ready_o drops
module string_escape_to_utf8_decoder_core import sue_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_run_o,
  output logic       string_done_o,
  output logic [1:0] error_code_o
);

  // front to queue
  logic push;
  run_t push_run;
  logic q_full;

  // queue to back
  logic head_valid;
  run_t head_run;
  logic pop;

  // front: classifies bytes, tracks escape state, forms runs
  sue_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .run_o        (push_run)
  );

  sue_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_run_i   (push_run),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_run_o   (head_run)
  );

  // back: expands each run into output words, one per cycle unless the receiver stalls
  sue_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_run_i    (head_run),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .string_done_o (string_done_o),
    .error_code_o  (error_code_o)
  );

endmodule

/* design/sue_checker.sv */
module sue_checker import sue_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       last_of_run_o,
  input logic       string_done_o,
  input logic [1:0] error_code_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o) && $stable(error_code_o))
    else $error("output word changed while stalled");

  // error-only word is exactly the bad code point word
  a_bad_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!byte_valid_o || error_code_o == ERR_BAD_CP) |->
      !byte_valid_o && error_code_o == ERR_BAD_CP && last_of_run_o
      && out_byte_o == 8'h00)
    else $error("bad code point word malformed");

  // a run continues in the next cycle with the same status
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=>
      out_valid_o && $stable(string_done_o) && $stable(error_code_o))
    else $error("run broken or status changed mid-run");

  // errors other than a bad code point only come from escapes; a bad hex word ends its run or carries a utf-8 byte
  a_plain_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_BAD_HEX |-> byte_valid_o && last_of_run_o
      || out_byte_o[7] && byte_valid_o)
    else $error("bad hex error on unexpected word");

endmodule

bind string_escape_to_utf8_decoder_core sue_checker u_sue_checker (.*);
